// File: hw/rtl/kwm_pkg.sv
// Package for the k-way sorted merge unit: sizes, field widths, codes and the
// structs that pass between the sequencer, the queue store and the top level.
// Depends on nothing.
package kwm_pkg;

    // Number of queues and entries per queue.
    localparam int LISTS = 4;
    localparam int DEPTH = 16;

    // Fixed field widths of the transaction payloads.
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;
    localparam int STAT_W = 2;

    // Derived widths.
    localparam int QW        = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW        = $clog2(DEPTH + 1);
    localparam int AW        = QW + PW;
    localparam int MEM_WORDS = LISTS * (1 << PW);

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Access to the queue store: one write port and one read port.
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic [AW-1:0]     raddr;
    } mem_req_t;

    // One finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
    } res_t;

endpackage

// File: hw/rtl/kwm_store.sv
// Queue store of the merge unit: all queues share one synchronous memory,
// one write and one read per cycle, read data registered. Depends on kwm_pkg.
module kwm_store (
    input  logic                          clk,
    input  kwm_pkg::mem_req_t             mem_req,
    output logic [kwm_pkg::DATA_W-1:0]    mem_rdata
);
    import kwm_pkg::*;

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign mem_rdata = rdata_reg;

endmodule

// File: hw/rtl/kwm_seq.sv
// Sequencer of the merge unit: queue pointers and fill counts, the head scan
// with one shared comparator, and the commit of appends and pops.
// Depends on kwm_pkg; drives the queue store through a kwm_pkg::mem_req_t.
module kwm_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [kwm_pkg::IDX_W-1:0]      list_index,
    input  logic signed [kwm_pkg::DATA_W-1:0] value,
    output logic                           res_valid,
    input  logic                           res_ready,
    output kwm_pkg::res_t                  res,
    output kwm_pkg::mem_req_t              mem_req,
    input  logic [kwm_pkg::DATA_W-1:0]     mem_rdata
);
    import kwm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPEND = 5'b00010,
        S_SCAN   = 5'b00100,
        S_LAST   = 5'b01000,
        S_POP    = 5'b10000
    } state_t;

    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [QW-1:0] Q_LAST   = QW'(LISTS - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    function automatic logic [PW-1:0] ptr_advance(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        begin
            n = (p == PTR_LAST) ? '0 : p + 1'b1;
            return n;
        end
    endfunction

    state_t state_reg, state_next;
    logic [PW-1:0] rptr_reg [LISTS];
    logic [PW-1:0] rptr_next [LISTS];
    logic [PW-1:0] wptr_reg [LISTS];
    logic [PW-1:0] wptr_next [LISTS];
    logic [FW-1:0] fill_reg [LISTS];
    logic [FW-1:0] fill_next [LISTS];
    logic [QW-1:0] scan_reg, scan_next;
    logic          found_reg, found_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [QW-1:0] rd_q_reg, rd_q_next;
    logic [QW-1:0] best_q_reg, best_q_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic signed [DATA_W-1:0] val_reg, val_next;

    logic [QW-1:0] cur_q;
    logic [PW-1:0] cur_rptr;
    logic [PW-1:0] cur_wptr;
    logic [FW-1:0] cur_fill;
    logic          idx_bad;
    logic          append_full;
    logic          cmp_take;
    logic          commit;

    // All pointer and count accesses go through one queue index per cycle.
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:   cur_q = scan_reg;
            S_POP:    cur_q = best_q_reg;
            S_IDLE,
            S_APPEND,
            S_LAST:   cur_q = QW'(idx_reg);
            default:  cur_q = QW'(idx_reg);
        endcase
    end

    assign cur_rptr    = rptr_reg[cur_q];
    assign cur_wptr    = wptr_reg[cur_q];
    assign cur_fill    = fill_reg[cur_q];
    assign idx_bad     = (32'(idx_reg) >= 32'(LISTS));
    assign append_full = idx_bad || (cur_fill == FILL_MAX);
    assign cmp_take    = rd_valid_reg &&
                         (!found_reg || ($signed(mem_rdata) < best_val_reg));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_APPEND) || (state_reg == S_POP);
    assign commit    = res_valid && res_ready;

    always_comb
    begin
        res.value  = '0;
        res.status = ST_OK;
        if (state_reg == S_APPEND)
        begin
            res.status = append_full ? ST_FULL : ST_OK;
        end
        else if (state_reg == S_POP)
        begin
            res.value  = found_reg ? best_val_reg : '0;
            res.status = found_reg ? ST_OK : ST_EMPTY;
        end
    end

    assign mem_req.we    = (state_reg == S_APPEND) && !append_full && commit;
    assign mem_req.waddr = {cur_q, cur_wptr};
    assign mem_req.wdata = val_reg;
    assign mem_req.raddr = {cur_q, cur_rptr};

    always_comb
    begin
        state_next    = state_reg;
        rptr_next     = rptr_reg;
        wptr_next     = wptr_reg;
        fill_next     = fill_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        rd_valid_next = 1'b0;
        rd_q_next     = rd_q_reg;
        best_q_next   = best_q_reg;
        best_val_next = best_val_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;

        // The head read issued in the previous cycle is compared here.
        if (cmp_take)
        begin
            found_next    = 1'b1;
            best_q_next   = rd_q_reg;
            best_val_next = $signed(mem_rdata);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = list_index;
                    val_next   = value;
                    found_next = 1'b0;
                    scan_next  = '0;
                    state_next = (op_t'(op) == OP_POP) ? S_SCAN : S_APPEND;
                end
            end
            S_SCAN:
            begin
                rd_valid_next = (cur_fill != '0);
                rd_q_next     = scan_reg;
                scan_next     = scan_reg + 1'b1;
                if (scan_reg == Q_LAST)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_POP;
            end
            S_APPEND:
            begin
                if (commit)
                begin
                    if (!append_full)
                    begin
                        wptr_next[cur_q] = ptr_advance(cur_wptr);
                        fill_next[cur_q] = cur_fill + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (commit)
                begin
                    if (found_reg)
                    begin
                        rptr_next[cur_q] = ptr_advance(cur_rptr);
                        fill_next[cur_q] = cur_fill - 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_reg     <= '0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            found_reg    <= found_next;
            rd_valid_reg <= rd_valid_next;
            rptr_reg     <= rptr_next;
            wptr_reg     <= wptr_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg     <= rd_q_next;
        best_q_reg   <= best_q_next;
        best_val_reg <= best_val_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
    end

endmodule

// File: hw/rtl/k_way_sorted_merge.sv
// Top level of the k-way sorted merge unit: sequencer, queue store and the
// output register. Depends on kwm_pkg, kwm_seq and kwm_store.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   op, list_index, value
//   out      output     out_valid / out_ready merged_value, status
//
// An append transaction is accepted in the idle state, then the value is written
// into the shared queue memory and the tail pointer is updated.
// A pop transaction is accepted the same way; then the queue
// heads are read one per cycle from the single memory read port and fed to
// one shared comparator, then the winning queue's pointers are updated.
// The result enters the output register as those pointers move; a new transaction
// is accepted while that result still waits for out_ready.
// Reset clears all pointers and fill counts at once; the memory itself is
// never cleared, since only entries that have been written are ever compared.
// A stalled output holds the sequencer at its commit step, so no pointer
// moves until the result has a place to go.
module k_way_sorted_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [kwm_pkg::IDX_W-1:0]         list_index,
    input  logic signed [kwm_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    output logic [kwm_pkg::STAT_W-1:0]        status
);
    import kwm_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [STAT_W-1:0]        status_reg, status_next;

    kwm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .list_index (list_index),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    kwm_store u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // The output register takes a new result when it is empty or being
    // drained in the same cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            value_next     = res.value;
            status_next    = STAT_W'(res.status);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign merged_value = value_reg;
    assign status       = status_reg;

endmodule

// File: hw/rtl/kwm_checker.sv
// Port-level checker for the k-way sorted merge unit, with the bind that
// attaches it to the top level. Depends on kwm_pkg.
module kwm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              op,
    input  logic [kwm_pkg::IDX_W-1:0]         list_index,
    input  logic signed [kwm_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [kwm_pkg::DATA_W-1:0] merged_value,
    input  logic [kwm_pkg::STAT_W-1:0]        status
);
    import kwm_pkg::*;

    // A waiting input transaction keeps its payload until it is accepted.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(op) && $stable(list_index)
            && $stable(value))
        else $error("input changed while waiting");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(merged_value) && $stable(status))
        else $error("result changed while stalled");

    // One transaction at a time: the block is busy in the cycle after it accepts.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted back to back");

    // A result with an error status carries a zero value.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> merged_value == '0)
        else $error("non-zero value with error status");

    // No undefined status code appears.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_EMPTY) || (status == ST_FULL))
        else $error("undefined status code");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);

// File: verif/k_way_sorted_merge_tb.sv
// Self-checking testbench for the k-way sorted merge unit: directed and random append
// and pop transactions under several idling patterns, checked against a queue predictor.
// Depends on kwm_pkg and the k_way_sorted_merge RTL.

// Scoreboard: keeps its own copy of the queues, works out the expected result of every
// accepted transaction and compares each delivered result with the oldest expectation.
class merge_scoreboard;

    typedef struct {
        logic signed [kwm_pkg::DATA_W-1:0] value;
        kwm_pkg::status_t                  status;
    } merge_result_t;

    logic signed [kwm_pkg::DATA_W-1:0] ring [kwm_pkg::LISTS][kwm_pkg::DEPTH];
    int            head [kwm_pkg::LISTS];
    int            fill [kwm_pkg::LISTS];
    merge_result_t awaited [$];
    int            errors = 0;

    function void note_input(kwm_pkg::op_t o, logic [kwm_pkg::IDX_W-1:0] idx,
                             logic signed [kwm_pkg::DATA_W-1:0] v);
        merge_result_t r;
        bit            found;
        int            best;
        r.value  = '0;
        r.status = kwm_pkg::ST_OK;
        found    = 1'b0;
        best     = 0;
        if (o == kwm_pkg::OP_APPEND)
        begin
            if (int'(idx) >= kwm_pkg::LISTS || fill[idx] >= kwm_pkg::DEPTH)
            begin
                r.status = kwm_pkg::ST_FULL;
            end
            else
            begin
                ring[idx][(head[idx] + fill[idx]) % kwm_pkg::DEPTH] = v;
                fill[idx]++;
            end
        end
        else
        begin
            // Strict less-than keeps the lowest queue index on equal heads.
            for (int i = 0; i < kwm_pkg::LISTS; i++)
            begin
                if (fill[i] != 0)
                begin
                    if (!found || ring[i][head[i]] < ring[best][head[best]])
                    begin
                        found = 1'b1;
                        best  = i;
                    end
                end
            end
            if (!found)
            begin
                r.status = kwm_pkg::ST_EMPTY;
            end
            else
            begin
                r.value    = ring[best][head[best]];
                head[best] = (head[best] + 1) % kwm_pkg::DEPTH;
                fill[best]--;
            end
        end
        awaited = {awaited, r};
    endfunction

    function void check_result(logic signed [kwm_pkg::DATA_W-1:0] v,
                               logic [kwm_pkg::STAT_W-1:0] s);
        merge_result_t r;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: value %0d status %0d", v, s);
            return;
        end
        r = awaited.pop_front();
        if (v !== r.value || s !== r.status)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                         r.value, r.status, v, s);
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction

endclass

module k_way_sorted_merge_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    // Cycles without any accepted transaction after which the run is declared hung.
    // The slowest item is a pop behind a long receiver stall, so
    // this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    localparam int SEGMENT_LEN = 30;
    localparam int SEGMENTS    = 5;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     op         = 1'b0;
    logic [IDX_W-1:0]         list_index = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] merged_value;
    logic [STAT_W-1:0]        status;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    merge_scoreboard sb = new();

    k_way_sorted_merge dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .list_index   (list_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .merged_value (merged_value),
        .status       (status)
    );

    always #5 clk = ~clk;

    // The receiver decides afresh at every falling edge whether to take a result.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(merged_value, status);
    end

    // Watchdog: any accepted transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one transaction, possibly after some idle cycles, and returns at the falling
    // edge after it has been accepted. Valid is left high so that a following transaction
    // can go out back to back; the payload only changes at a falling edge.
    task automatic send_item(input op_t o, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        list_index <= idx;
        value      <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(o, idx, v);
        @(negedge clk);
    endtask

    // Lowers valid and holds the sender back until every outstanding result has come.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                       append_pct;
        int                       favourite;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] v;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run with no idling on either side.
        // A pop before anything has been appended must report empty.
        send_item(OP_POP, 2'd0, 32'sd0);
        // Extremes of the value range, one in each queue, then drained in signed order.
        send_item(OP_APPEND, 2'd0, 32'sh7fff_ffff);
        send_item(OP_APPEND, 2'd1, 32'sh8000_0000);
        send_item(OP_APPEND, 2'd2, 32'sd0);
        send_item(OP_APPEND, 2'd3, -32'sd1);
        send_item(OP_POP, 2'd3, 32'sh5a5a_a5a5);
        send_item(OP_POP, 2'd1, 32'sh7fff_ffff);
        send_item(OP_POP, 2'd2, -32'sd1);
        send_item(OP_POP, 2'd0, 32'sh8000_0000);
        send_item(OP_POP, 2'd3, 32'sd0);
        // Equal heads in queues 0 and 2: queue 0 must win, which the values behind the
        // heads make visible (the order would be 5, 1, 5, 100 if queue 2 won).
        send_item(OP_APPEND, 2'd2, 32'sd5);
        send_item(OP_APPEND, 2'd2, 32'sd1);
        send_item(OP_APPEND, 2'd0, 32'sd5);
        send_item(OP_APPEND, 2'd0, 32'sd100);
        send_item(OP_POP, 2'd0, 32'sd0);
        send_item(OP_POP, 2'd0, 32'sd0);
        send_item(OP_POP, 2'd0, 32'sd0);
        send_item(OP_POP, 2'd0, 32'sd0);
        drain();

        // Random part in four idling phases. Within a phase, segments lean towards
        // appending or popping or keep the two even, and favour one queue, so queues run full, wrap
        // their pointers and drain to empty.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                case ($urandom_range(2))
                    0:       append_pct = 85;
                    1:       append_pct = 50;
                    default: append_pct = 15;
                endcase
                favourite = $urandom_range(LISTS - 1);
                for (int n = 0; n < SEGMENT_LEN; n++)
                begin
                    // Narrow values give plenty of equal heads; the rest cover all bits.
                    case ($urandom_range(9))
                        0, 1, 2, 3: v = $urandom;
                        4, 5, 6:    v = int'($urandom_range(15)) - 8;
                        7:          v = 32'sh8000_0000;
                        8:          v = 32'sh7fff_ffff;
                        default:    v = -32'sd1;
                    endcase
                    if ($urandom_range(99) < 75)
                        idx = favourite[IDX_W-1:0];
                    else
                        idx = IDX_W'($urandom_range(3));
                    if ($urandom_range(99) < append_pct)
                        send_item(OP_APPEND, idx, v);
                    else
                        send_item(OP_POP, idx, v);
                end
            end
            // The sender waits here until every result of the phase has been delivered.
            drain();
        end

        // Give the block time to show any result that nobody asked for.
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
